// ===== src/sat_pkg.sv =====
package sat_pkg;

  // Table geometry.
  localparam int unsigned MaxSections = 16;
  localparam int unsigned IdxW        = $clog2(MaxSections);
  localparam int unsigned CntW        = $clog2(MaxSections + 1);

  // Fixed field widths.
  localparam int unsigned AddrW  = 32;
  localparam int unsigned SlotW  = 4;
  localparam int unsigned CountW = 5;

  // Command codes carried by an input beat.
  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdLookup = 1'b1;

  // One table entry as stored: start, exclusive 33-bit end and the
  // precomputed difference file_pointer - start.
  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [AddrW:0]   stop;
    logic [AddrW-1:0] delta;
  } sat_entry_t;

  // Answer of the compare unit for one entry.
  typedef struct packed {
    logic             hit;
    logic [AddrW-1:0] offset;
  } sat_match_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StResp = 3'b100
  } sat_state_e;

endpackage

// ===== src/section_address_translator.sv =====
// Channel  | Handshake                | Payload
// ---------+--------------------------+---------------------------------------------
// in       | in_valid_i / in_ready_o  | cmd, entry_index, section_start, raw_size,
//          |                          | virtual_size, file_pointer, lookup_address
// out      | out_valid_o / out_ready_i| file_offset, found
// cfg      | cfg_valid_i / cfg_ready_o| cfg_data_i (section_count)
//
// A load beat leaves the sequencer idle, so the block stays ready for the next beat.
// A lookup scans N = min(section_count, 16) entries and stops early on a hit:
// the single compare unit sees one table entry per cycle from the registered
// RAM read port.
// Reset clears the sequencer, the output valid flag and section_count; the
// table itself holds garbage until loaded. The result sits in an output
// register, so a stalled output only delays the end of the next lookup.
module section_address_translator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sat_pkg::CountW-1:0]    cfg_data_i,
  // Input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [sat_pkg::SlotW-1:0]     entry_index_i,
  input  logic [sat_pkg::AddrW-1:0]     section_start_i,
  input  logic [sat_pkg::AddrW-1:0]     raw_size_i,
  input  logic [sat_pkg::AddrW-1:0]     virtual_size_i,
  input  logic [sat_pkg::AddrW-1:0]     file_pointer_i,
  input  logic [sat_pkg::AddrW-1:0]     lookup_address_i,
  // Results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sat_pkg::AddrW-1:0]     file_offset_o,
  output logic                          found_o
);
  import sat_pkg::*;

  localparam int unsigned EntryW = $bits(sat_entry_t);

  sat_state_e       state_q, state_d;
  logic [CountW-1:0] count_q;
  logic [CntW-1:0]  limit_q, limit_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic             pend_q, pend_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [AddrW-1:0] res_off_q, res_off_d;
  logic             res_found_q, res_found_d;
  logic             out_valid_q;
  logic [AddrW-1:0] out_off_q;
  logic             out_found_q;

  logic             in_fire;
  logic             load_we;
  logic [AddrW-1:0] load_size;
  sat_entry_t       load_entry;
  logic [EntryW-1:0] rd_data;
  sat_entry_t       rd_entry;
  sat_match_t       match;
  logic             issue;
  logic             out_free;
  logic             resp_fire;

  // Configuration register, always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  // Input side and table load. The entry is stored with its end and its
  // offset difference already worked out.
  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign load_we    = in_fire && (cmd_i == CmdLoad) &&
                      (32'(entry_index_i) < MaxSections);
  assign load_size  = (raw_size_i != '0) ? raw_size_i : virtual_size_i;

  always_comb begin
    load_entry.start = section_start_i;
    load_entry.stop  = {1'b0, section_start_i} + {1'b0, load_size};
    load_entry.delta = file_pointer_i - section_start_i;
  end

  sat_ram #(
    .Width (EntryW),
    .Depth (MaxSections)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (IdxW'(entry_index_i)),
    .wdata_i (load_entry),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (rd_data)
  );

  assign rd_entry = sat_entry_t'(rd_data);

  sat_match u_match (
    .addr_i  (addr_q),
    .entry_i (rd_entry),
    .match_o (match)
  );

  // Scan sequencer: one read issued and one compare done per cycle.
  assign issue     = rd_idx_q < limit_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign resp_fire = (state_q == StResp) && out_free;

  always_comb begin
    state_d     = state_q;
    limit_d     = limit_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    addr_d      = addr_q;
    res_off_d   = res_off_q;
    res_found_d = res_found_q;
    unique case (state_q)
      StIdle: begin
        if (in_fire && (cmd_i == CmdLookup)) begin
          state_d  = StScan;
          addr_d   = lookup_address_i;
          rd_idx_d = '0;
          pend_d   = 1'b0;
          limit_d  = (32'(count_q) > MaxSections) ? CntW'(MaxSections)
                                                  : CntW'(count_q);
        end
      end
      StScan: begin
        if (pend_q && match.hit) begin
          state_d     = StResp;
          res_off_d   = match.offset;
          res_found_d = 1'b1;
        end else if (!issue) begin
          state_d     = StResp;
          res_off_d   = '0;
          res_found_d = 1'b0;
        end else begin
          rd_idx_d = rd_idx_q + 1'b1;
          pend_d   = 1'b1;
        end
      end
      StResp: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      limit_q  <= '0;
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      limit_q  <= limit_d;
      rd_idx_q <= rd_idx_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    res_off_q   <= res_off_d;
    res_found_q <= res_found_d;
  end

  // Output register holding one result beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_fire) begin
      out_off_q   <= res_off_q;
      out_found_q <= res_found_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign file_offset_o = out_off_q;
  assign found_o       = out_found_q;

  // A miss always reports a zero offset.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> file_offset_o == '0)
    else $error("miss delivered with nonzero offset");

  // The read pointer never runs past the scan limit.
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_idx_q <= limit_q && 32'(limit_q) <= MaxSections)
    else $error("scan pointer beyond limit");

  // A lookup beat closes the input until its result is loaded into the output register.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CmdLookup |=> !in_ready_o)
    else $error("input reopened during lookup");

  // Leaving the response state always loads the output register.
  a_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StResp && out_free |=> out_valid_o && state_q == StIdle)
    else $error("result not delivered");

endmodule

// ===== src/sat_ram.sv =====
module sat_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/sat_match.sv =====
module sat_match (
  input  logic [sat_pkg::AddrW-1:0] addr_i,
  input  sat_pkg::sat_entry_t       entry_i,
  output sat_pkg::sat_match_t       match_o
);
  import sat_pkg::*;

  logic ge_start;
  logic lt_stop;

  // The address hits when it lies in [start, stop); the offset is the
  // address plus the stored difference, wrapping at 32 bits.
  assign ge_start       = addr_i >= entry_i.start;
  assign lt_stop        = {1'b0, addr_i} < entry_i.stop;
  assign match_o.hit    = ge_start && lt_stop;
  assign match_o.offset = addr_i + entry_i.delta;

endmodule

// ===== verif/tb_section_address_translator.sv =====
`timescale 1ns / 1ps

// One input beat as driven onto the block's ports.
typedef struct {
  logic                         cmd;
  logic [sat_pkg::SlotW-1:0]    slot;
  logic [sat_pkg::AddrW-1:0]    start;
  logic [sat_pkg::AddrW-1:0]    raw;
  logic [sat_pkg::AddrW-1:0]    virt;
  logic [sat_pkg::AddrW-1:0]    fptr;
  logic [sat_pkg::AddrW-1:0]    addr;
} section_beat_t;

// One translation answer as expected on the result channel.
typedef struct {
  logic [sat_pkg::AddrW-1:0] offset;
  logic                      found;
} translation_t;

// Keeps a private copy of the section table and the scan count, and holds
// the translations that the block still owes.
class section_scoreboard;
  logic [sat_pkg::AddrW-1:0]  tbl_start [sat_pkg::MaxSections];
  logic [sat_pkg::AddrW-1:0]  tbl_size  [sat_pkg::MaxSections];
  logic [sat_pkg::AddrW-1:0]  tbl_fptr  [sat_pkg::MaxSections];
  logic [sat_pkg::CountW-1:0] scan_count;
  translation_t               offset_fifo [$];
  int unsigned                fail_count;

  function new();
    scan_count = '0;
    fail_count = 0;
  endfunction

  function void set_count(logic [sat_pkg::CountW-1:0] value);
    scan_count = value;
  endfunction

  function int unsigned pending();
    return offset_fifo.size();
  endfunction

  // First entry holding the address wins; the end is a 33-bit sum so an
  // entry that runs past the top of the address space does not wrap.
  function translation_t translate(logic [sat_pkg::AddrW-1:0] addr);
    translation_t             res;
    int unsigned              lim;
    logic [sat_pkg::AddrW:0]  stop;
    lim = (scan_count > sat_pkg::MaxSections) ? sat_pkg::MaxSections : scan_count;
    res.offset = '0;
    res.found  = 1'b0;
    for (int unsigned k = 0; k < lim; k++) begin
      stop = {1'b0, tbl_start[k]} + {1'b0, tbl_size[k]};
      if (addr >= tbl_start[k] && {1'b0, addr} < stop) begin
        res.offset = (addr - tbl_start[k]) + tbl_fptr[k];
        res.found  = 1'b1;
        return res;
      end
    end
    return res;
  endfunction

  // A load updates the table; a lookup queues its expected translation.
  function void note_beat(section_beat_t b);
    if (b.cmd == sat_pkg::CmdLoad) begin
      if (b.slot < sat_pkg::MaxSections) begin
        tbl_start[b.slot] = b.start;
        tbl_size[b.slot]  = (b.raw != '0) ? b.raw : b.virt;
        tbl_fptr[b.slot]  = b.fptr;
      end
    end else begin
      offset_fifo.push_back(translate(b.addr));
    end
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  task check_result(logic [sat_pkg::AddrW-1:0] offset, logic found);
    translation_t want;
    if (offset_fifo.size() == 0) begin
      report_mismatch($sformatf("result with nothing pending: offset %h found %b",
                                offset, found));
    end else begin
      want = offset_fifo.pop_front();
      if (offset !== want.offset)
        report_mismatch($sformatf("file_offset got %h want %h", offset, want.offset));
      if (found !== want.found)
        report_mismatch($sformatf("found got %b want %b", found, want.found));
    end
  endtask
endclass

module tb_section_address_translator;

  localparam int unsigned SettleCycles  = 24;
  localparam int unsigned DrainCycles   = 24;
  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned PhaseBeats    = 180;

  // Receiver behavior, redrawn at random by the ready process below.
  typedef enum logic [1:0] {
    RdyAlways,
    RdyCoin,
    RdyPeriodic,
    RdyScarce
  } ready_mode_e;

  logic                         clk_i            = 1'b0;
  logic                         rst_ni           = 1'b0;
  logic                         cfg_valid_i      = 1'b0;
  logic                         cfg_ready_o;
  logic [sat_pkg::CountW-1:0]   cfg_data_i       = '0;
  logic                         in_valid_i       = 1'b0;
  logic                         in_ready_o;
  logic                         cmd_i            = sat_pkg::CmdLoad;
  logic [sat_pkg::SlotW-1:0]    entry_index_i    = '0;
  logic [sat_pkg::AddrW-1:0]    section_start_i  = '0;
  logic [sat_pkg::AddrW-1:0]    raw_size_i       = '0;
  logic [sat_pkg::AddrW-1:0]    virtual_size_i   = '0;
  logic [sat_pkg::AddrW-1:0]    file_pointer_i   = '0;
  logic [sat_pkg::AddrW-1:0]    lookup_address_i = '0;
  logic                         out_valid_o;
  logic                         out_ready_i      = 1'b0;
  logic [sat_pkg::AddrW-1:0]    file_offset_o;
  logic                         found_o;

  section_scoreboard sb = new();
  ready_mode_e       ready_mode = RdyAlways;
  int unsigned       ready_tick = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       burst_left = 0;

  section_address_translator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cmd_i            (cmd_i),
    .entry_index_i    (entry_index_i),
    .section_start_i  (section_start_i),
    .raw_size_i       (raw_size_i),
    .virtual_size_i   (virtual_size_i),
    .file_pointer_i   (file_pointer_i),
    .lookup_address_i (lookup_address_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .file_offset_o    (file_offset_o),
    .found_o          (found_o)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Receiver stalls: always ready, coin flips, a fixed period, or long stalls.
  always @(posedge clk_i) begin
    ready_tick <= ready_tick + 1;
    if (ready_tick % 256 == 0) ready_mode <= ready_mode_e'($urandom_range(0, 3));
    case (ready_mode)
      RdyAlways:   out_ready_i <= 1'b1;
      RdyCoin:     out_ready_i <= 1'($urandom_range(0, 1));
      RdyPeriodic: out_ready_i <= (ready_tick % 5) >= 2;
      default:     out_ready_i <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // Every result beat is checked against the oldest pending translation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(file_offset_o, found_o);
  end

  // Ends the run when no channel has moved a beat for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic section_beat_t load_beat(logic [3:0] slot, logic [31:0] start,
                                              logic [31:0] raw, logic [31:0] virt,
                                              logic [31:0] fptr);
    section_beat_t b;
    b.cmd   = sat_pkg::CmdLoad;
    b.slot  = slot;
    b.start = start;
    b.raw   = raw;
    b.virt  = virt;
    b.fptr  = fptr;
    b.addr  = $urandom;
    return b;
  endfunction

  function automatic section_beat_t lookup_beat(logic [31:0] addr);
    section_beat_t b;
    b       = load_beat(4'($urandom_range(0, 15)), $urandom, $urandom, $urandom, $urandom);
    b.cmd   = sat_pkg::CmdLookup;
    b.addr  = addr;
    return b;
  endfunction

  // Mostly lookups aimed at and around the edges of live entries; loads
  // mix tiny, zero, full-range and overlapping sections.
  function automatic section_beat_t random_beat();
    section_beat_t b;
    int unsigned   lim;
    int unsigned   k;
    logic [31:0]   s;
    logic [31:0]   z;
    b = lookup_beat($urandom);
    if ($urandom_range(0, 9) < 3) begin
      b.cmd = sat_pkg::CmdLoad;
      case ($urandom_range(0, 7))
        0:       b.start = '0;
        1:       b.start = 32'hFFFF_FFFF - $urandom_range(0, 4095);
        2:       b.start = sb.tbl_start[$urandom_range(0, 15)];
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: b.raw = $urandom_range(1, 4096);
        4: begin
          b.raw  = '0;
          b.virt = $urandom_range(1, 4096);
        end
        5: begin
          b.raw  = '0;
          b.virt = '0;
        end
        6:       ;
        7:       b.raw = '0;
        8:       b.raw = 32'd1;
        default: b.raw = 32'hFFFF_FFFF;
      endcase
    end else begin
      lim = (sb.scan_count > sat_pkg::MaxSections) ? sat_pkg::MaxSections : sb.scan_count;
      if (lim != 0) begin
        k = $urandom_range(0, lim - 1);
        s = sb.tbl_start[k];
        z = sb.tbl_size[k];
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: b.addr = s + ((z == 0) ? 32'd0 : ($urandom % z));
          5:             b.addr = s - 1;
          6:             b.addr = s + z;
          7:             b.addr = s + z - 1;
          default:       ;
        endcase
      end
    end
    return b;
  endfunction

  // Holds the beat on the input channel until it is taken.
  task automatic send_beat(input section_beat_t b);
    in_valid_i       <= 1'b1;
    cmd_i            <= b.cmd;
    entry_index_i    <= b.slot;
    section_start_i  <= b.start;
    raw_size_i       <= b.raw;
    virtual_size_i   <= b.virt;
    file_pointer_i   <= b.fptr;
    lookup_address_i <= b.addr;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(b);
  endtask

  // Sender bursts of random length separated by random gaps.
  task automatic pace();
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  // The count is only changed with the block idle: nothing owed and any
  // trailing load or scan given time to finish.
  task automatic write_count(input logic [sat_pkg::CountW-1:0] value);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_count(value);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    logic [sat_pkg::CountW-1:0] phase_counts [10];
    phase_counts = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17, 5'd8, 5'd3, 5'd12, 5'd16, 5'd5};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // With no entries in use nothing is ever found.
    write_count(5'd0);
    send_beat(lookup_beat(32'h0000_0000));
    send_beat(lookup_beat(32'hFFFF_FFFF));

    // Fill every slot: virtual size fallback, a zero-size entry, an entry
    // running past the top of memory, a wrapping offset and an overlap.
    send_beat(load_beat(4'd0, 32'h0000_0000, 32'h0000_0100, 32'h0, 32'h0000_0400));
    send_beat(load_beat(4'd1, 32'h0000_1000, 32'h0, 32'h0000_0200, 32'h0000_2000));
    send_beat(load_beat(4'd2, 32'h0000_3000, 32'h0, 32'h0, 32'h0000_9000));
    send_beat(load_beat(4'd3, 32'hFFFF_F000, 32'h0000_2000, 32'h0, 32'h0000_8000));
    send_beat(load_beat(4'd4, 32'h0000_5000, 32'h0000_0010, 32'h0, 32'hFFFF_FFF8));
    send_beat(load_beat(4'd5, 32'h0000_1000, 32'h0000_1000, 32'h0, 32'h0007_0000));
    for (int unsigned k = 6; k < 15; k++) begin
      send_beat(load_beat(4'(k), k << 24, 32'h0000_1000, $urandom, k << 16));
    end
    send_beat(load_beat(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));

    write_count(5'd16);
    send_beat(lookup_beat(32'h0000_0000));
    send_beat(lookup_beat(32'h0000_1100));
    send_beat(lookup_beat(32'h0000_1300));
    send_beat(lookup_beat(32'h0000_3000));
    send_beat(lookup_beat(32'hFFFF_FFFF));
    send_beat(lookup_beat(32'h0000_500F));
    send_beat(lookup_beat(32'h0E00_0FFF));

    // Random traffic over a sequence of scan counts, extremes included.
    foreach (phase_counts[p]) begin
      write_count(phase_counts[p]);
      repeat (PhaseBeats) begin
        send_beat(random_beat());
        pace();
      end
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
